### src/icmp_echo_reply_frame_filter_assert.svh
// assertion macros for the echo reply frame filter
// depends on nothing; included by modules that carry checks
`ifndef ICMP_ECHO_REPLY_FRAME_FILTER_ASSERT_SVH
`define ICMP_ECHO_REPLY_FRAME_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define IEFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iefr check failed");
`define IEFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iefr check failed");
`else
`define IEFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IEFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/iefr_pkg.sv
// shared types, constants and the payload pattern for the echo reply filter
// depends on nothing
package iefr_pkg;

	localparam logic [11:0] MAX_FRAME_BYTES = 12'd2048;
	localparam logic [11:0] PAYLOAD_BYTES   = 12'd9;
	localparam logic [3:0]  PAT_LEN         = 4'd9;
	localparam logic [11:0] ETH_LEN         = 12'd14;
	localparam logic [5:0]  IP_MIN_LEN      = 6'd20;
	localparam logic [11:0] ICMP_LEN        = 12'd8;
	localparam logic [11:0] MIN_FRAME       = 12'd42;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP      = 8'h01;
	localparam logic [3:0]  IHL_MASK        = 4'hF;

	localparam logic [11:0] POS_ETHERTYPE = 12'd13;
	localparam logic [11:0] POS_IHL       = 12'd14;
	localparam logic [11:0] POS_PROTOCOL  = 12'd23;
	localparam logic [11:0] POS_SOURCE    = 12'd29;
	localparam logic [11:0] POS_DEST      = 12'd33;
	localparam logic [11:0] OFS_TYPECODE  = 12'd1;
	localparam logic [11:0] OFS_IDENT     = 12'd5;
	localparam logic [11:0] OFS_SEQ       = 12'd7;

	localparam logic [15:0] ECHO_ID_RESET  = 16'h5153;
	localparam logic [15:0] ECHO_SEQ_RESET = 16'h0001;

	typedef enum logic [1:0] {
		CFG_LOCAL_ADDR   = 2'd0,
		CFG_GATEWAY_ADDR = 2'd1,
		CFG_ECHO_ID      = 2'd2,
		CFG_ECHO_SEQ     = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		RSN_MATCH         = 4'd0,
		RSN_SHORT         = 4'd1,
		RSN_ETHERTYPE     = 4'd2,
		RSN_IHL           = 4'd3,
		RSN_PROTOCOL      = 4'd4,
		RSN_ADDRESS       = 4'd5,
		RSN_TYPECODE      = 4'd6,
		RSN_ID_SEQ        = 4'd7,
		RSN_PAYLOAD_SHORT = 4'd8,
		RSN_PAYLOAD_DIFF  = 4'd9
	} reason_t;

	typedef enum logic [3:0] {
		FLG_ETHERTYPE = 4'd0,
		FLG_IHL       = 4'd1,
		FLG_PROTOCOL  = 4'd2,
		FLG_SOURCE    = 4'd3,
		FLG_DEST      = 4'd4,
		FLG_TYPECODE  = 4'd5,
		FLG_IDENT     = 4'd6,
		FLG_SEQ       = 4'd7,
		FLG_PAYLOAD   = 4'd8
	} flag_t;

	localparam int NUM_FLAGS = 9;

	typedef struct packed {
		logic [31:0] local_addr;
		logic [31:0] gateway_addr;
		logic [15:0] echo_id;
		logic [15:0] echo_seq;
	} cfg_t;

	typedef struct packed {
		logic    match;
		reason_t reason;
	} result_t;

	// expected payload byte, repeating every PAT_LEN bytes
	function automatic logic [7:0] pattern_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h51;
			4'd1: b = 8'h4F;
			4'd2: b = 8'h53;
			4'd3: b = 8'h49;
			4'd4: b = 8'h43;
			4'd5: b = 8'h4D;
			4'd6: b = 8'h50;
			4'd7: b = 8'h52;
			4'd8: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### src/iefr_cfg_regs.sv
// configuration registers of the echo reply filter
// depends on iefr_pkg
module iefr_cfg_regs
	import iefr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_addr   <= '0;
			cfg_q.gateway_addr <= '0;
			cfg_q.echo_id      <= ECHO_ID_RESET;
			cfg_q.echo_seq     <= ECHO_SEQ_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LOCAL_ADDR:   cfg_q.local_addr   <= cfg_data;
				CFG_GATEWAY_ADDR: cfg_q.gateway_addr <= cfg_data;
				CFG_ECHO_ID:      cfg_q.echo_id      <= cfg_data[15:0];
				CFG_ECHO_SEQ:     cfg_q.echo_seq     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/iefr_frame_check.sv
// per-byte frame state, field checks and end-of-frame verdict
// depends on iefr_pkg
module iefr_frame_check
	import iefr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] frame_byte,
	input  logic       last_byte,
	output result_t    res
);

	logic [11:0]          pos_q, pos_n;
	logic [5:0]           hl_q, hl_n;
	logic [31:0]          shift_q, shift_n;
	logic [NUM_FLAGS-1:0] flags_q, flags_n;
	logic [3:0]           pat_q, pat_n;
	logic [11:0]          icmp;
	logic [11:0]          pay_start;
	logic [11:0]          icmp_n;
	reason_t              reason;

	always_comb begin
		pos_n     = pos_q;
		hl_n      = hl_q;
		shift_n   = shift_q;
		flags_n   = flags_q;
		pat_n     = pat_q;
		icmp      = ETH_LEN + 12'(hl_q);
		pay_start = icmp + ICMP_LEN;
		if (pos_q < MAX_FRAME_BYTES) begin
			shift_n = {shift_q[23:0], frame_byte};
			pos_n   = pos_q + 12'd1;
			if (pos_q == POS_ETHERTYPE && shift_n[15:0] != ETHERTYPE_IPV4)
				flags_n[FLG_ETHERTYPE] = 1'b0;
			if (pos_q == POS_IHL) begin
				hl_n = {frame_byte[3:0] & IHL_MASK, 2'b00};
				if (hl_n < IP_MIN_LEN)
					flags_n[FLG_IHL] = 1'b0;
			end
			if (pos_q == POS_PROTOCOL && frame_byte != PROTO_ICMP)
				flags_n[FLG_PROTOCOL] = 1'b0;
			if (pos_q == POS_SOURCE && shift_n != cfg.gateway_addr)
				flags_n[FLG_SOURCE] = 1'b0;
			if (pos_q == POS_DEST && shift_n != cfg.local_addr)
				flags_n[FLG_DEST] = 1'b0;
			if (pos_q == icmp + OFS_TYPECODE && shift_n[15:0] != 16'h0000)
				flags_n[FLG_TYPECODE] = 1'b0;
			if (pos_q == icmp + OFS_IDENT && shift_n[15:0] != cfg.echo_id)
				flags_n[FLG_IDENT] = 1'b0;
			if (pos_q == icmp + OFS_SEQ && shift_n[15:0] != cfg.echo_seq)
				flags_n[FLG_SEQ] = 1'b0;
			if (pos_q >= pay_start && pos_q < pay_start + PAYLOAD_BYTES) begin
				if (frame_byte != pattern_byte(pat_q))
					flags_n[FLG_PAYLOAD] = 1'b0;
				pat_n = (pat_q == PAT_LEN - 4'd1) ? 4'd0 : pat_q + 4'd1;
			end
		end
	end

	// verdict on the state including this byte
	always_comb begin
		icmp_n = ETH_LEN + 12'(hl_n) + ICMP_LEN;
		if (pos_n < MIN_FRAME)
			reason = RSN_SHORT;
		else if (!flags_n[FLG_ETHERTYPE])
			reason = RSN_ETHERTYPE;
		else if (!flags_n[FLG_IHL] || hl_n < IP_MIN_LEN || pos_n < icmp_n)
			reason = RSN_IHL;
		else if (!flags_n[FLG_PROTOCOL])
			reason = RSN_PROTOCOL;
		else if (!flags_n[FLG_SOURCE] || !flags_n[FLG_DEST])
			reason = RSN_ADDRESS;
		else if (!flags_n[FLG_TYPECODE])
			reason = RSN_TYPECODE;
		else if (!flags_n[FLG_IDENT] || !flags_n[FLG_SEQ])
			reason = RSN_ID_SEQ;
		else if (icmp_n + PAYLOAD_BYTES > pos_n)
			reason = RSN_PAYLOAD_SHORT;
		else if (!flags_n[FLG_PAYLOAD])
			reason = RSN_PAYLOAD_DIFF;
		else
			reason = RSN_MATCH;
	end

	assign res.reason = reason;
	assign res.match  = (reason == RSN_MATCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hl_q    <= '0;
			shift_q <= '0;
			flags_q <= '1;
			pat_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q   <= '0;
				hl_q    <= '0;
				shift_q <= '0;
				flags_q <= '1;
				pat_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				hl_q    <= hl_n;
				shift_q <= shift_n;
				flags_q <= flags_n;
				pat_q   <= pat_n;
			end
		end
	end

endmodule

### src/iefr_out_reg.sv
// result register on the master side of the echo reply filter
// depends on iefr_pkg and the assertion macro header
`include "icmp_echo_reply_frame_filter_assert.svh"
module iefr_out_reg
	import iefr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000, res_q.reason, res_q.match};

	`IEFR_ASSERT_NOW(a_no_overwrite, clk, arst_n, load, !valid_q || m_axis_tready)
	`IEFR_ASSERT_NOW(a_reason_range, clk, arst_n, valid_q, res_q.reason <= RSN_PAYLOAD_DIFF)
	`IEFR_ASSERT_NOW(a_match_agrees, clk, arst_n, valid_q, res_q.match == (res_q.reason == RSN_MATCH))

endmodule

### src/icmp_echo_reply_frame_filter.sv
// channel   dir  width  contents
// s_axis    in   8+1    tdata frame byte, tlast last byte of frame
// m_axis    out  8      tdata match bit, reject reason
// cfg       in   2+32   register index, write data
//
// one byte per cycle unless s_axis stalls; a byte enters the input register,
// is checked there, and a frame end loads the verdict into the result register
// the input register keeps taking bytes while a verdict waits; only a second
// frame end behind an untaken verdict stalls s_axis
// no clearing pass after reset; arst_n resets frame state, valid flags and cfg registers
// depends on iefr_pkg, iefr_cfg_regs, iefr_frame_check, iefr_out_reg
module icmp_echo_reply_frame_filter
	import iefr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] is_echo_reply, [4:1] reject_reason
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t       cfg;
	result_t    res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	iefr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a frame end may only move on when the result register can take it
	assign advance       = valid_s1 && (!last_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	iefr_frame_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (advance),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.res        (res)
	);

	iefr_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && last_s1),
		.res           (res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
